// ===== hw/rtl/acwt_pkg.sv =====
// Shared types and constants for the AN-code minimum arithmetic weight search.
// No dependencies; every other file of the block imports this package.
package acwt_pkg;

	localparam int MAX_DATA_WIDTH_DEF = 24;
	localparam int MAX_A_WIDTH_DEF    = 24;

	localparam int A_W     = 24;
	localparam int WIDTH_W = 5;
	localparam int WGT_W   = 6;
	localparam int MINW_W  = 7;
	localparam int CNT_W   = 24;

	localparam logic [WIDTH_W-1:0] DATA_WIDTH_RST = 5'd16;
	localparam logic [MINW_W-1:0]  MINW_NONE      = 7'd64;
	localparam logic [MINW_W-1:0]  WGT_SAT        = 7'd63;

	typedef enum logic [1:0] {
		ST_DROP = 2'd0,
		ST_TIE  = 2'd1,
		ST_NEW  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FINISH
	} seq_state_t;

	// sequencer commands to the multiple generator and weight pipeline
	typedef struct packed {
		logic start;
		logic flush;
	} acwt_ctl_t;

endpackage

// ===== hw/rtl/acwt_mult_gen.sv =====
// Multiple generator: one shared adder steps x through A, 2A, 3A, ... one per cycle.
// Depends on acwt_pkg for the control struct.
module acwt_mult_gen #(
	parameter int MAX_A_WIDTH    = acwt_pkg::MAX_A_WIDTH_DEF,
	parameter int MAX_DATA_WIDTH = acwt_pkg::MAX_DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  acwt_pkg::acwt_ctl_t                   ctl,
	input  logic [MAX_A_WIDTH-1:0]                a,
	input  logic [MAX_DATA_WIDTH-1:0]             dmax,
	output logic [MAX_A_WIDTH+MAX_DATA_WIDTH-1:0] x,
	output logic                                  x_valid,
	output logic                                  x_last
);
	import acwt_pkg::*;

	localparam int XW = MAX_A_WIDTH + MAX_DATA_WIDTH;

	logic [XW-1:0]             x_q;
	logic [MAX_A_WIDTH-1:0]    a_q;
	logic [MAX_DATA_WIDTH-1:0] cnt_q;
	logic [MAX_DATA_WIDTH-1:0] dmax_q;
	logic                      busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.flush) begin
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && x_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q    <= XW'(a);
			a_q    <= a;
			cnt_q  <= MAX_DATA_WIDTH'(1);
			dmax_q <= dmax;
		end else if (busy_q) begin
			x_q   <= x_q + XW'(a_q);
			cnt_q <= cnt_q + MAX_DATA_WIDTH'(1);
		end
	end

	assign x       = x_q;
	assign x_valid = busy_q;
	assign x_last  = (cnt_q == dmax_q);

endmodule

// ===== hw/rtl/acwt_naf_weight.sv =====
// NAF weight pipeline: popcount(x ^ 3x) over three stages, saturated to 63.
// Depends on acwt_pkg for widths and the control struct.
module acwt_naf_weight #(
	parameter int MAX_A_WIDTH    = acwt_pkg::MAX_A_WIDTH_DEF,
	parameter int MAX_DATA_WIDTH = acwt_pkg::MAX_DATA_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  acwt_pkg::acwt_ctl_t                   ctl,
	input  logic [MAX_A_WIDTH+MAX_DATA_WIDTH-1:0] x,
	input  logic                                  x_valid,
	input  logic                                  x_last,
	output logic [acwt_pkg::WGT_W-1:0]            w,
	output logic                                  w_valid,
	output logic                                  w_last
);
	import acwt_pkg::*;

	localparam int XW = MAX_A_WIDTH + MAX_DATA_WIDTH;
	localparam int TW = (XW + 2 > 64) ? 64 : XW + 2;
	localparam int NB = (TW + 7) / 8;

	logic [TW-1:0]     x3;
	logic [TW-1:0]     t_s1;
	logic              v_s1, last_s1;
	logic [NB*8-1:0]   t_pad;
	logic [3:0]        bc_nxt [NB];
	logic [3:0]        bc_s2  [NB];
	logic              v_s2, last_s2;
	logic [MINW_W-1:0] sum;
	logic [WGT_W-1:0]  w_s3;
	logic              v_s3, last_s3;

	// 3x wraps modulo 2^64 only when the words are widened that far
	assign x3    = TW'(x) + TW'({x, 1'b0});
	assign t_pad = (NB*8)'(t_s1);

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			bc_nxt[b] = 4'd0;
			for (int i = 0; i < 8; i++) begin
				bc_nxt[b] = bc_nxt[b] + 4'(t_pad[b*8+i]);
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int b = 0; b < NB; b++) begin
			sum = sum + MINW_W'(bc_s2[b]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctl.flush) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= x_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= TW'(x) ^ x3;
		last_s1 <= x_last;
		bc_s2   <= bc_nxt;
		last_s2 <= last_s1;
		w_s3    <= (sum > WGT_SAT) ? WGT_SAT[WGT_W-1:0] : sum[WGT_W-1:0];
		last_s3 <= last_s2;
	end

	assign w       = w_s3;
	assign w_valid = v_s3;
	assign w_last  = last_s3;

endmodule

// ===== hw/rtl/acwt_seq.sv =====
// Sequencer: request intake, running minimum, early stop, best weight and count,
// and the result register. Depends on acwt_pkg.
module acwt_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [acwt_pkg::A_W-1:0]    a_value,
	input  logic                        start_new,
	output acwt_pkg::acwt_ctl_t         ctl,
	input  logic [acwt_pkg::WGT_W-1:0]  w,
	input  logic                        w_valid,
	input  logic                        w_last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [acwt_pkg::A_W-1:0]    a_echo,
	output logic [acwt_pkg::WGT_W-1:0]  weight,
	output logic [1:0]                  status,
	output logic [acwt_pkg::WGT_W-1:0]  best_weight,
	output logic [acwt_pkg::CNT_W-1:0]  candidate_count
);
	import acwt_pkg::*;

	seq_state_t        state_q, state_nxt;
	logic              accept, stop, load;
	logic [MINW_W-1:0] minw_q, minw_upd;
	logic [WGT_W-1:0]  best_q, best_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_nxt;
	status_t           status_nxt;
	logic [A_W-1:0]    echo_q;
	logic              out_valid_q;
	logic [A_W-1:0]    a_echo_q;
	logic [WGT_W-1:0]  weight_q, best_out_q;
	status_t           status_q;
	logic [CNT_W-1:0]  cnt_out_q;

	assign minw_upd = (MINW_W'(w) < minw_q) ? MINW_W'(w) : minw_q;
	assign load     = (state_q == S_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		accept    = 1'b0;
		stop      = 1'b0;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: begin
				accept = in_valid;
				if (in_valid) begin
					ctl.start = 1'b1;
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				// the first multiple below the best, or the last multiple, ends the walk
				if (w_valid && ((MINW_W'(w) < MINW_W'(best_q)) || w_last)) begin
					stop      = 1'b1;
					ctl.flush = 1'b1;
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (load) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		best_nxt   = best_q;
		cnt_nxt    = cnt_q;
		status_nxt = ST_DROP;
		if (minw_q > MINW_W'(best_q)) begin
			best_nxt   = minw_q[WGT_W-1:0];
			cnt_nxt    = CNT_W'(1);
			status_nxt = ST_NEW;
		end else if (minw_q == MINW_W'(best_q)) begin
			status_nxt = ST_TIE;
			if (cnt_q != '1) begin
				cnt_nxt = cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && start_new) begin
				best_q <= '0;
				cnt_q  <= '0;
			end else if (load) begin
				best_q <= best_nxt;
				cnt_q  <= cnt_nxt;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			echo_q <= a_value;
			minw_q <= MINW_NONE;
		end else if (state_q == S_RUN && w_valid) begin
			minw_q <= minw_upd;
		end
		if (load) begin
			a_echo_q   <= echo_q;
			weight_q   <= minw_q[WGT_W-1:0];
			status_q   <= status_nxt;
			best_out_q <= best_nxt;
			cnt_out_q  <= cnt_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign a_echo          = a_echo_q;
	assign weight          = weight_q;
	assign status          = status_q;
	assign best_weight     = best_out_q;
	assign candidate_count = cnt_out_q;

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && start_new) |=> best_q >= $past(best_q))
		else $error("best weight fell without a restart");

	a_run_not_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (minw_q >= MINW_W'(best_q)))
		else $error("walk continued past a weight below best");

	a_new_best_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load && status_nxt == ST_NEW) |=> (cnt_q == CNT_W'(1)))
		else $error("count not restarted on new best");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (best_out_q == best_q && cnt_out_q == cnt_q))
		else $error("result disagrees with held best weight or count");

	a_stop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		stop |=> (state_q == S_FINISH) && !w_valid)
		else $error("weight pipeline not flushed on stop");

endmodule

// ===== hw/rtl/an_code_min_arith_weight_search.sv =====
// Minimum arithmetic weight search for AN-code multipliers, top level.
// The shared adder produces one multiple A*d per cycle, d = 1 .. 2^k - 1 (k = data_width);
// early stop ends the walk sooner.
// Throughput: one request at a time; the next is taken the cycle after the result loads.
// Reset: arst_n clears best weight, count and control; data_width returns to 16.
// Depends on acwt_pkg, acwt_mult_gen, acwt_naf_weight and acwt_seq.
module an_code_min_arith_weight_search #(
	parameter int MAX_DATA_WIDTH = acwt_pkg::MAX_DATA_WIDTH_DEF,
	parameter int MAX_A_WIDTH    = acwt_pkg::MAX_A_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [acwt_pkg::WIDTH_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [acwt_pkg::A_W-1:0]      a_value,
	input  logic                          start_new,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [acwt_pkg::A_W-1:0]      a_echo,
	output logic [acwt_pkg::WGT_W-1:0]    weight,
	output logic [1:0]                    status,
	output logic [acwt_pkg::WGT_W-1:0]    best_weight,
	output logic [acwt_pkg::CNT_W-1:0]    candidate_count
);
	import acwt_pkg::*;

	localparam int XW = MAX_A_WIDTH + MAX_DATA_WIDTH;

	logic [WIDTH_W-1:0]        data_width_q;
	logic [5:0]                k_eff;
	logic [MAX_DATA_WIDTH:0]   span;
	logic [MAX_DATA_WIDTH-1:0] dmax;
	logic [63:0]               a_wide;
	logic [MAX_A_WIDTH-1:0]    a_m;
	acwt_ctl_t                 ctl;
	logic [XW-1:0]             x;
	logic                      x_valid, x_last;
	logic [WGT_W-1:0]          w;
	logic                      w_valid, w_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_width_q <= DATA_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			data_width_q <= cfg_data;
		end
	end

	// clamp the word width into 1 .. MAX_DATA_WIDTH
	always_comb begin
		if (data_width_q == '0) begin
			k_eff = 6'd1;
		end else if (6'(data_width_q) > 6'(MAX_DATA_WIDTH)) begin
			k_eff = 6'(MAX_DATA_WIDTH);
		end else begin
			k_eff = 6'(data_width_q);
		end
	end

	assign span   = ((MAX_DATA_WIDTH+1)'(1) << k_eff) - (MAX_DATA_WIDTH+1)'(1);
	assign dmax   = span[MAX_DATA_WIDTH-1:0];
	assign a_wide = 64'(a_value);
	assign a_m    = a_wide[MAX_A_WIDTH-1:0];

	acwt_mult_gen #(
		.MAX_A_WIDTH   (MAX_A_WIDTH),
		.MAX_DATA_WIDTH(MAX_DATA_WIDTH)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.a      (a_m),
		.dmax   (dmax),
		.x      (x),
		.x_valid(x_valid),
		.x_last (x_last)
	);

	acwt_naf_weight #(
		.MAX_A_WIDTH   (MAX_A_WIDTH),
		.MAX_DATA_WIDTH(MAX_DATA_WIDTH)
	) u_wgt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.x      (x),
		.x_valid(x_valid),
		.x_last (x_last),
		.w      (w),
		.w_valid(w_valid),
		.w_last (w_last)
	);

	acwt_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.a_value        (a_value),
		.start_new      (start_new),
		.ctl            (ctl),
		.w              (w),
		.w_valid        (w_valid),
		.w_last         (w_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.a_echo         (a_echo),
		.weight         (weight),
		.status         (status),
		.best_weight    (best_weight),
		.candidate_count(candidate_count)
	);

endmodule
